>>> rtl/casd_pkg.sv
// Package with shared types, constants and codes of the color animation stream decoder.
`default_nettype none
package casd_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_HEIGHT = 1'd1;

    localparam logic [7:0] WIDTH_RESET  = 8'd98;
    localparam logic [7:0] HEIGHT_RESET = 8'd70;

    // Header contents.
    localparam logic [7:0] MAGIC [4] = '{8'h43, 8'h41, 8'h4E, 8'h49};
    localparam logic [7:0] FILE_VERSION = 8'h02;

    // Display controller commands.
    localparam logic [7:0] CMD_COL = 8'h2A;
    localparam logic [7:0] CMD_ROW = 8'h2B;
    localparam logic [7:0] CMD_MEM = 8'h2C;

    localparam logic [7:0] OP_WINDOW = 8'hC0;

    // Result kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_PAUSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Header error codes.
    localparam logic [1:0] ERR_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_WIDTH   = 2'd2;
    localparam logic [1:0] ERR_HEIGHT  = 2'd3;

    localparam logic [5:0] WINDOW_FRAMES = 6'd7;

    typedef enum logic [2:0] {
        BK_FRAME,
        BK_REPEAT,
        BK_WINDOW,
        BK_PAUSE,
        BK_ERROR
    } burst_kind_t;

    // A group of results caused by one input byte.
    typedef struct packed {
        logic        valid;
        burst_kind_t kind;
        logic [5:0]  len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [10:0] pause_ms;
        logic [1:0]  error_code;
    } burst_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_data;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [1:0]  byte_count;
        logic [10:0] pause_ms;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/casd_in_if.sv
// Input byte channel of the color animation stream decoder.
`default_nettype none
interface casd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink (input valid, input data_byte, input file_start, output ready);
endinterface
`default_nettype wire

>>> rtl/casd_out_if.sv
// Result channel of the color animation stream decoder.
`default_nettype none
interface casd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        is_data;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [1:0]  byte_count;
    logic [10:0] pause_ms;
    logic [1:0]  error_code;
    logic        last;

    modport source (
        output valid, output kind, output is_data, output byte_a, output byte_b,
        output byte_count, output pause_ms, output error_code, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input is_data, input byte_a, input byte_b,
        input byte_count, input pause_ms, input error_code, input last,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/casd_cfg_if.sv
// Configuration write channel of the color animation stream decoder.
`default_nettype none
interface casd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [casd_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> rtl/casd_parser.sv
// Parser state of the decoder: turns accepted bytes that cause results into burst descriptors.
`default_nettype none
module casd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic             file_start,
    input  wire logic [7:0]       expected_width,
    input  wire logic [7:0]       expected_height,
    output casd_pkg::burst_t      desc
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_HALT,
        PH_DIRECTIVE,
        PH_OPCODE,
        PH_LITERAL,
        PH_REP1,
        PH_REP2,
        PH_WINDOW
    } phase_t;

    phase_t     phase_reg,     phase_next;
    logic [2:0] hpos_reg,      hpos_next;
    logic [3:0] hfault_reg,    hfault_next;
    logic [7:0] block_rem_reg, block_rem_next;
    logic [7:0] lit_rem_reg,   lit_rem_next;
    logic [5:0] rep_cnt_reg,   rep_cnt_next;
    logic [7:0] rep_first_reg, rep_first_next;
    logic [1:0] win_idx_reg,   win_idx_next;
    logic [7:0] win_bytes_reg [3];
    logic       win_we;

    phase_t     ph;
    logic [2:0] hpos;
    logic [3:0] hf;
    logic [3:0] hf_new;
    logic [7:0] brem;
    logic [7:0] brem_dec;
    logic [7:0] lit_dec;

    always_comb
    begin
        // A file start restarts header parsing with this byte.
        ph   = file_start ? PH_HEADER : phase_reg;
        hpos = file_start ? 3'd0 : hpos_reg;
        hf   = file_start ? 4'd0 : hfault_reg;
        brem = file_start ? 8'd0 : block_rem_reg;

        phase_next     = ph;
        hpos_next      = hpos;
        hfault_next    = hf;
        block_rem_next = brem;
        lit_rem_next   = lit_rem_reg;
        rep_cnt_next   = rep_cnt_reg;
        rep_first_next = rep_first_reg;
        win_idx_next   = win_idx_reg;
        win_we         = 1'b0;
        hf_new         = hf;
        brem_dec       = brem - 8'd1;
        lit_dec        = lit_rem_reg - 8'd1;

        desc            = '0;
        desc.kind       = casd_pkg::BK_FRAME;
        desc.len        = 6'd1;
        desc.b0         = data_byte;

        case (ph)
            PH_HEADER:
            begin
                if (hpos < 3'd4) begin
                    hf_new[0] = hf[0] | (data_byte != casd_pkg::MAGIC[hpos[1:0]]);
                end else if (hpos == 3'd4) begin
                    hf_new[1] = hf[1] | (data_byte != casd_pkg::FILE_VERSION);
                end else if (hpos == 3'd5) begin
                    hf_new[2] = hf[2] | (data_byte != expected_width);
                end else begin
                    hf_new[3] = hf[3] | (data_byte != expected_height);
                end
                hfault_next = hf_new;
                if (hpos < 3'd6) begin
                    hpos_next = hpos + 3'd1;
                end else begin
                    hpos_next  = 3'd0;
                    desc.valid = 1'b1;
                    if (hf_new != 4'd0) begin
                        phase_next = PH_HALT;
                        desc.kind  = casd_pkg::BK_ERROR;
                        if (hf_new[0]) begin
                            desc.error_code = casd_pkg::ERR_MAGIC;
                        end else if (hf_new[1]) begin
                            desc.error_code = casd_pkg::ERR_VERSION;
                        end else if (hf_new[2]) begin
                            desc.error_code = casd_pkg::ERR_WIDTH;
                        end else begin
                            desc.error_code = casd_pkg::ERR_HEIGHT;
                        end
                    end else begin
                        phase_next = PH_DIRECTIVE;
                        desc.kind  = casd_pkg::BK_WINDOW;
                        desc.len   = casd_pkg::WINDOW_FRAMES;
                        desc.b0    = 8'd0;
                        desc.b1    = expected_width - 8'd1;
                        desc.b2    = 8'd0;
                        desc.b3    = expected_height - 8'd1;
                    end
                end
            end
            PH_HALT:
            begin
            end
            PH_DIRECTIVE:
            begin
                if (data_byte[7]) begin
                    desc.valid    = 1'b1;
                    desc.kind     = casd_pkg::BK_PAUSE;
                    desc.pause_ms = {1'b0, data_byte[6:0], 3'b000}
                                  + {3'b000, data_byte[6:0], 1'b0};
                end else begin
                    block_rem_next = {data_byte[6:0], 1'b0};
                    if (data_byte[6:0] != 7'd0) begin
                        phase_next = PH_OPCODE;
                    end
                end
            end
            default:
            begin
                // Instruction bytes inside a block.
                case (ph)
                    PH_OPCODE:
                    begin
                        if (!data_byte[7]) begin
                            lit_rem_next = {data_byte[6:0], 1'b0};
                            if (data_byte[6:0] != 7'd0) begin
                                phase_next = PH_LITERAL;
                            end
                        end else if (!data_byte[6]) begin
                            rep_cnt_next = data_byte[5:0];
                            phase_next   = PH_REP1;
                        end else if (data_byte == casd_pkg::OP_WINDOW) begin
                            win_idx_next = 2'd0;
                            phase_next   = PH_WINDOW;
                        end
                    end
                    PH_LITERAL:
                    begin
                        desc.valid   = 1'b1;
                        lit_rem_next = lit_dec;
                        if (lit_dec == 8'd0) begin
                            phase_next = PH_OPCODE;
                        end
                    end
                    PH_REP1:
                    begin
                        rep_first_next = data_byte;
                        phase_next     = PH_REP2;
                    end
                    PH_REP2:
                    begin
                        desc.valid = (rep_cnt_reg != 6'd0);
                        desc.kind  = casd_pkg::BK_REPEAT;
                        desc.len   = rep_cnt_reg;
                        desc.b0    = rep_first_reg;
                        desc.b1    = data_byte;
                        phase_next = PH_OPCODE;
                    end
                    default:
                    begin
                        if (win_idx_reg != 2'd3) begin
                            win_we       = 1'b1;
                            win_idx_next = win_idx_reg + 2'd1;
                        end else begin
                            desc.valid   = 1'b1;
                            desc.kind    = casd_pkg::BK_WINDOW;
                            desc.len     = casd_pkg::WINDOW_FRAMES;
                            desc.b0      = win_bytes_reg[0];
                            desc.b1      = win_bytes_reg[1];
                            desc.b2      = win_bytes_reg[2];
                            desc.b3      = data_byte;
                            win_idx_next = 2'd0;
                            phase_next   = PH_OPCODE;
                        end
                    end
                endcase
                // A block end drops whatever instruction is still partial.
                block_rem_next = brem_dec;
                if (brem_dec == 8'd0) begin
                    phase_next = PH_DIRECTIVE;
                end
            end
        endcase

        if (!accept) begin
            desc.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_HEADER;
            hpos_reg      <= 3'd0;
            hfault_reg    <= 4'd0;
            block_rem_reg <= 8'd0;
            lit_rem_reg   <= 8'd0;
            rep_cnt_reg   <= 6'd0;
            rep_first_reg <= 8'd0;
            win_idx_reg   <= 2'd0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            hpos_reg      <= hpos_next;
            hfault_reg    <= hfault_next;
            block_rem_reg <= block_rem_next;
            lit_rem_reg   <= lit_rem_next;
            rep_cnt_reg   <= rep_cnt_next;
            rep_first_reg <= rep_first_next;
            win_idx_reg   <= win_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && win_we) begin
            win_bytes_reg[win_idx_reg] <= data_byte;
        end
    end

endmodule
`default_nettype wire

>>> rtl/color_animation_stream_decoder.sv
// Top level of the color animation stream decoder.
//
// The block reads an animation file one byte per request on byte_stream and
// produces display-controller frames, pause requests and header error reports
// on result. Configuration writes on cfg set the frame width and height that
// the header must declare; cfg is always ready and should be written only
// while the decoder is idle.
//
// The first result of an accepted byte passes the burst register, then the
// output register. A byte that causes at most one result is taken every cycle
// while result.ready stays high. A byte that causes a burst (a repeated pixel
// of N results, or a window change of seven frames) holds byte_stream.ready
// low until the burst register has handed its last result to the output
// register, so such a byte occupies the single burst emitter. Every result of
// a burst comes from the same byte, and the final one carries last.
//
// Reset clears the parser to header parsing, empties the burst and output
// registers and restores the default frame size of 98 by 70. When the
// receiver stalls, the output register holds its result, the burst register
// waits, and input ready falls once the burst register is occupied.
`default_nettype none
module color_animation_stream_decoder (
    input wire logic   clk,
    input wire logic   rst_n,
    casd_in_if.sink    byte_stream,
    casd_out_if.source result,
    casd_cfg_if.sink   cfg
);

    logic [7:0] width_reg;
    logic [7:0] height_reg;

    casd_pkg::burst_t  desc;
    casd_pkg::burst_t  burst_reg;
    logic              burst_valid_reg;
    logic [5:0]        idx_reg;

    logic              out_valid_reg;
    casd_pkg::result_t out_reg;
    casd_pkg::result_t out_next;

    logic accept;
    logic emit;
    logic burst_last;
    logic in_ready;

    // Configuration registers; the port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= casd_pkg::WIDTH_RESET;
            height_reg <= casd_pkg::HEIGHT_RESET;
        end else if (cfg.valid) begin
            case (cfg.index)
                casd_pkg::CFG_EXPECTED_WIDTH:  width_reg  <= cfg.wdata;
                casd_pkg::CFG_EXPECTED_HEIGHT: height_reg <= cfg.wdata;
                default:
                begin
                end
            endcase
        end
    end

    // The emitter moves one result from the burst register into the output
    // register whenever that register is empty or being drained.
    assign emit       = burst_valid_reg && (!out_valid_reg || result.ready);
    assign burst_last = (idx_reg == (burst_reg.len - 6'd1));
    assign in_ready   = !burst_valid_reg || (emit && burst_last);
    assign accept     = byte_stream.valid && in_ready;

    assign byte_stream.ready = in_ready;

    casd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (byte_stream.data_byte),
        .file_start      (byte_stream.file_start),
        .expected_width  (width_reg),
        .expected_height (height_reg),
        .desc            (desc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= 6'd0;
        end else if (desc.valid) begin
            burst_valid_reg <= 1'b1;
            idx_reg         <= 6'd0;
        end else if (emit) begin
            if (burst_last) begin
                burst_valid_reg <= 1'b0;
                idx_reg         <= 6'd0;
            end else begin
                idx_reg <= idx_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc.valid) begin
            burst_reg <= desc;
        end
    end

    // Build the result at the current position of the burst.
    always_comb
    begin
        out_next            = '0;
        out_next.last       = burst_last;
        case (burst_reg.kind)
            casd_pkg::BK_FRAME:
            begin
                out_next.kind       = casd_pkg::KIND_WRITE;
                out_next.is_data    = 1'b1;
                out_next.byte_a     = burst_reg.b0;
                out_next.byte_count = 2'd1;
            end
            casd_pkg::BK_REPEAT:
            begin
                out_next.kind       = casd_pkg::KIND_WRITE;
                out_next.is_data    = 1'b1;
                out_next.byte_a     = burst_reg.b0;
                out_next.byte_b     = burst_reg.b1;
                out_next.byte_count = 2'd2;
            end
            casd_pkg::BK_WINDOW:
            begin
                out_next.kind       = casd_pkg::KIND_WRITE;
                out_next.byte_count = 2'd1;
                out_next.is_data    = 1'b1;
                case (idx_reg[2:0])
                    3'd0:
                    begin
                        out_next.is_data = 1'b0;
                        out_next.byte_a  = casd_pkg::CMD_COL;
                    end
                    3'd1: out_next.byte_a = burst_reg.b0;
                    3'd2: out_next.byte_a = burst_reg.b1;
                    3'd3:
                    begin
                        out_next.is_data = 1'b0;
                        out_next.byte_a  = casd_pkg::CMD_ROW;
                    end
                    3'd4: out_next.byte_a = burst_reg.b2;
                    3'd5: out_next.byte_a = burst_reg.b3;
                    default:
                    begin
                        out_next.is_data = 1'b0;
                        out_next.byte_a  = casd_pkg::CMD_MEM;
                    end
                endcase
            end
            casd_pkg::BK_PAUSE:
            begin
                out_next.kind     = casd_pkg::KIND_PAUSE;
                out_next.pause_ms = burst_reg.pause_ms;
            end
            default:
            begin
                out_next.kind       = casd_pkg::KIND_ERROR;
                out_next.error_code = burst_reg.error_code;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (result.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_reg <= out_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = out_reg.kind;
    assign result.is_data    = out_reg.is_data;
    assign result.byte_a     = out_reg.byte_a;
    assign result.byte_b     = out_reg.byte_b;
    assign result.byte_count = out_reg.byte_count;
    assign result.pause_ms   = out_reg.pause_ms;
    assign result.error_code = out_reg.error_code;
    assign result.last       = out_reg.last;

endmodule
`default_nettype wire

>>> rtl/casd_checker.sv
// Port-level assertions for the color animation stream decoder, bound to the top level.
`default_nettype none
module casd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic [1:0]  kind,
    input wire logic        is_data,
    input wire logic [7:0]  byte_a,
    input wire logic [1:0]  byte_count,
    input wire logic [10:0] pause_ms,
    input wire logic [1:0]  error_code,
    input wire logic        last
);

    // A stalled result stays and keeps its display byte, kind and last flag.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(byte_a) && $stable(kind) && $stable(last))
        else $error("stalled result changed");

    // Pause and error reports stand alone and carry no display bytes.
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind != 2'd0) |-> last && (byte_count == 2'd0) && !is_data)
        else $error("report result malformed");

    // Display writes carry bytes and no report fields.
    a_write: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind == 2'd0) |-> (byte_count != 2'd0) && (pause_ms == 11'd0)
                                    && (error_code == 2'd0))
        else $error("display write malformed");

    // A two-byte frame is always pixel data.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (byte_count == 2'd2) |-> is_data)
        else $error("pixel pair marked as command");

endmodule

bind color_animation_stream_decoder casd_checker u_casd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (result.valid),
    .ready      (result.ready),
    .kind       (result.kind),
    .is_data    (result.is_data),
    .byte_a     (result.byte_a),
    .byte_count (result.byte_count),
    .pause_ms   (result.pause_ms),
    .error_code (result.error_code),
    .last       (result.last)
);
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the color animation stream decoder.
`timescale 1ns / 100ps

module tb_top;

    // Cycle budget for the whole run. A correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Cycles allowed after the last expected result before the block counts as idle.
    localparam int SETTLE_CYCLES = 12;
    // Length of the one long receiver stall that backs the block up.
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam logic [10:0] PAUSE_STEP_MS = 11'd10;
    localparam logic [1:0] REPEAT_TAG = 2'b10;

    // States of the decoder as the prediction tracks them.
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_HALTED,
        ST_DIRECTIVE,
        ST_OPCODE,
        ST_LITERAL,
        ST_REP_FIRST,
        ST_REP_SECOND,
        ST_WINDOW
    } parse_state_t;

    // One request on the byte stream.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } file_byte_t;

    logic clk;
    logic rst_n;

    casd_in_if  bs_if ();
    casd_out_if res_if ();
    casd_cfg_if cfg_if ();

    color_animation_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_stream(bs_if),
        .result     (res_if),
        .cfg        (cfg_if)
    );

    always #2 clk = ~clk;

    // Frame size the header must declare, as the block was last configured.
    logic [7:0] cfg_width = casd_pkg::WIDTH_RESET;
    logic [7:0] cfg_height = casd_pkg::HEIGHT_RESET;

    // Decoder state mirrored by the prediction.
    parse_state_t parse_state = ST_HEADER;
    logic [2:0] hdr_pos = '0;
    logic [3:0] hdr_faults = '0;
    logic [7:0] block_left = '0;
    logic [7:0] literal_left = '0;
    logic [5:0] rep_count = '0;
    logic [7:0] rep_first = '0;
    logic [7:0] win_bytes [3];
    logic [1:0] win_idx = '0;

    // Results produced by the byte under decode, and all results still to arrive.
    casd_pkg::result_t decoded_frames [$];
    casd_pkg::result_t awaited_frames [$];

    // Stimulus bookkeeping shared by the stimulus process, driver, receiver and monitor.
    file_byte_t bytes_to_send [$];
    int bytes_queued = 0;
    int bytes_accepted = 0;
    bit gaps_enabled = 1'b1;
    int hold_requests = 0;

    int cycle_count = 0;
    int failures = 0;
    int writes_seen = 0;
    int pauses_seen = 0;
    int errors_seen = 0;

    // Handshake flags sampled at the rising edge and used by the falling-edge drivers.
    logic byte_taken = 1'b0;
    logic result_taken = 1'b0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void add_result(input logic [1:0] kind, input logic is_data,
                                       input logic [7:0] a, input logic [7:0] b,
                                       input logic [1:0] cnt, input logic [10:0] ms,
                                       input logic [1:0] err);
        casd_pkg::result_t r;
        r.kind = kind;
        r.is_data = is_data;
        r.byte_a = a;
        r.byte_b = b;
        r.byte_count = cnt;
        r.pause_ms = ms;
        r.error_code = err;
        r.last = 1'b0;
        decoded_frames.push_back(r);
    endfunction

    function automatic void add_frame(input logic is_data, input logic [7:0] v);
        add_result(casd_pkg::KIND_WRITE, is_data, v, 8'd0, 2'd1, 11'd0,
                   casd_pkg::ERR_MAGIC);
    endfunction

    // A window change is a column command, two column bytes, a row command,
    // two row bytes and the memory write command.
    function automatic void add_window(input logic [7:0] xs, input logic [7:0] xe,
                                       input logic [7:0] ys, input logic [7:0] ye);
        add_frame(1'b0, casd_pkg::CMD_COL);
        add_frame(1'b1, xs);
        add_frame(1'b1, xe);
        add_frame(1'b0, casd_pkg::CMD_ROW);
        add_frame(1'b1, ys);
        add_frame(1'b1, ye);
        add_frame(1'b0, casd_pkg::CMD_MEM);
    endfunction

    // Works out every result that one accepted byte causes and appends them,
    // with the last one marked, to the results still to arrive.
    task automatic decode_file_byte(input logic [7:0] d, input logic fs);
        casd_pkg::result_t tail;
        logic [1:0] code;
        int n;
        if (fs)
        begin
            parse_state = ST_HEADER;
            hdr_pos = '0;
            hdr_faults = '0;
            block_left = '0;
        end
        case (parse_state)
            ST_HEADER:
            begin
                if (hdr_pos < 3'd4)
                begin
                    if (d != casd_pkg::MAGIC[hdr_pos[1:0]]) hdr_faults[0] = 1'b1;
                end
                else if (hdr_pos == 3'd4)
                begin
                    if (d != casd_pkg::FILE_VERSION) hdr_faults[1] = 1'b1;
                end
                else if (hdr_pos == 3'd5)
                begin
                    if (d != cfg_width) hdr_faults[2] = 1'b1;
                end
                else if (d != cfg_height)
                begin
                    hdr_faults[3] = 1'b1;
                end
                if (hdr_pos < 3'd6)
                begin
                    hdr_pos = hdr_pos + 3'd1;
                end
                else
                begin
                    hdr_pos = '0;
                    if (hdr_faults != 4'd0)
                    begin
                        // Only the first fault in header order is reported.
                        code = hdr_faults[0] ? casd_pkg::ERR_MAGIC :
                               hdr_faults[1] ? casd_pkg::ERR_VERSION :
                               hdr_faults[2] ? casd_pkg::ERR_WIDTH : casd_pkg::ERR_HEIGHT;
                        parse_state = ST_HALTED;
                        add_result(casd_pkg::KIND_ERROR, 1'b0, 8'd0, 8'd0, 2'd0, 11'd0,
                                   code);
                    end
                    else
                    begin
                        parse_state = ST_DIRECTIVE;
                        add_window(8'd0, cfg_width - 8'd1, 8'd0, cfg_height - 8'd1);
                    end
                end
            end
            ST_HALTED:
            begin
            end
            ST_DIRECTIVE:
            begin
                if (d[7])
                begin
                    add_result(casd_pkg::KIND_PAUSE, 1'b0, 8'd0, 8'd0, 2'd0,
                               11'(d[6:0]) * PAUSE_STEP_MS, casd_pkg::ERR_MAGIC);
                end
                else
                begin
                    block_left = {d[6:0], 1'b0};
                    if (block_left != 8'd0) parse_state = ST_OPCODE;
                end
            end
            default:
            begin
                case (parse_state)
                    ST_OPCODE:
                    begin
                        if (!d[7])
                        begin
                            literal_left = {d[6:0], 1'b0};
                            if (literal_left != 8'd0) parse_state = ST_LITERAL;
                        end
                        else if (d[7:6] == REPEAT_TAG)
                        begin
                            rep_count = d[5:0];
                            parse_state = ST_REP_FIRST;
                        end
                        else if (d == casd_pkg::OP_WINDOW)
                        begin
                            win_idx = '0;
                            parse_state = ST_WINDOW;
                        end
                    end
                    ST_LITERAL:
                    begin
                        add_frame(1'b1, d);
                        literal_left = literal_left - 8'd1;
                        if (literal_left == 8'd0) parse_state = ST_OPCODE;
                    end
                    ST_REP_FIRST:
                    begin
                        rep_first = d;
                        parse_state = ST_REP_SECOND;
                    end
                    ST_REP_SECOND:
                    begin
                        for (n = 0; n < int'(rep_count); n++)
                            add_result(casd_pkg::KIND_WRITE, 1'b1, rep_first, d, 2'd2,
                                       11'd0, casd_pkg::ERR_MAGIC);
                        parse_state = ST_OPCODE;
                    end
                    default:
                    begin
                        if (win_idx < 2'd3)
                        begin
                            win_bytes[win_idx] = d;
                            win_idx = win_idx + 2'd1;
                        end
                        else
                        begin
                            add_window(win_bytes[0], win_bytes[1], win_bytes[2], d);
                            win_idx = '0;
                            parse_state = ST_OPCODE;
                        end
                    end
                endcase
                // A block that runs out drops whatever instruction is half done.
                block_left = block_left - 8'd1;
                if (block_left == 8'd0) parse_state = ST_DIRECTIVE;
            end
        endcase
        if (decoded_frames.size() != 0)
        begin
            tail = decoded_frames.pop_back();
            tail.last = 1'b1;
            decoded_frames.push_back(tail);
            while (decoded_frames.size() != 0)
                awaited_frames.push_back(decoded_frames.pop_front());
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string show(input casd_pkg::result_t r);
        return $sformatf(
            "kind=%0d is_data=%0d a=%02h b=%02h count=%0d ms=%0d err=%0d last=%0d",
            r.kind, r.is_data, r.byte_a, r.byte_b, r.byte_count,
            r.pause_ms, r.error_code, r.last);
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    endfunction

    task automatic check_frame(input casd_pkg::result_t got);
        casd_pkg::result_t want;
        if (awaited_frames.size() == 0)
        begin
            note_failure({"unexpected result: ", show(got)});
        end
        else
        begin
            want = awaited_frames.pop_front();
            if (got.kind !== want.kind || got.is_data !== want.is_data ||
                got.byte_a !== want.byte_a || got.byte_b !== want.byte_b ||
                got.byte_count !== want.byte_count || got.pause_ms !== want.pause_ms ||
                got.error_code !== want.error_code || got.last !== want.last)
            begin
                note_failure({"expected ", show(want), " got ", show(got)});
            end
            else if (got.kind == casd_pkg::KIND_WRITE)
            begin
                writes_seen++;
            end
            else if (got.kind == casd_pkg::KIND_PAUSE)
            begin
                pauses_seen++;
            end
            else
            begin
                errors_seen++;
            end
        end
    endtask

    // The monitor samples both channels at the rising edge. An accepted byte
    // request is decoded before any result of the same edge is checked, and
    // the run is cut off if it overstays the cycle budget.
    always @(posedge clk)
    begin
        casd_pkg::result_t got;
        byte_taken <= rst_n && bs_if.valid && bs_if.ready;
        result_taken <= rst_n && res_if.valid && res_if.ready;
        if (rst_n)
        begin
            cycle_count++;
            if (bs_if.valid && bs_if.ready)
            begin
                decode_file_byte(bs_if.data_byte, bs_if.file_start);
                bytes_accepted++;
            end
            if (res_if.valid && res_if.ready)
            begin
                got.kind = res_if.kind;
                got.is_data = res_if.is_data;
                got.byte_a = res_if.byte_a;
                got.byte_b = res_if.byte_b;
                got.byte_count = res_if.byte_count;
                got.pause_ms = res_if.pause_ms;
                got.error_code = res_if.error_code;
                got.last = res_if.last;
                check_frame(got);
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding.",
                         cycle_count, awaited_frames.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------

    // The driver offers byte requests from the pending queue. After each accepted
    // request it draws a random gap before the next one, unless gaps are turned
    // off for the current phase.
    file_byte_t held_byte = '0;
    logic byte_held = 1'b0;
    int send_gap = 0;

    always @(negedge clk)
    begin
        if (byte_taken)
        begin
            byte_held = 1'b0;
            send_gap = gaps_enabled ? $urandom_range(0, 11) : 0;
        end
        else if (!byte_held && send_gap != 0)
        begin
            send_gap--;
        end
        if (!byte_held && send_gap == 0 && bytes_to_send.size() != 0)
        begin
            held_byte = bytes_to_send.pop_front();
            byte_held = 1'b1;
        end
        bs_if.valid <= byte_held;
        bs_if.data_byte <= held_byte.data_byte;
        bs_if.file_start <= held_byte.file_start;
    end

    // The receiver stalls for a random count of cycles after each accepted result, unless gaps are turned off.
    // A long hold asked for by the stimulus process is counted down here too.
    int sink_wait = 0;
    int holds_served = 0;

    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            sink_wait = LONG_HOLD_CYCLES;
        end
        else if (result_taken)
        begin
            sink_wait = gaps_enabled ? $urandom_range(0, 11) : 0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait--;
        end
        res_if.ready <= rst_n && (sink_wait == 0);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void queue_byte(input logic [7:0] d, input logic fs);
        file_byte_t b;
        b.data_byte = d;
        b.file_start = fs;
        bytes_to_send.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void queue_good_header();
        queue_byte(casd_pkg::MAGIC[0], 1'b1);
        queue_byte(casd_pkg::MAGIC[1], 1'b0);
        queue_byte(casd_pkg::MAGIC[2], 1'b0);
        queue_byte(casd_pkg::MAGIC[3], 1'b0);
        queue_byte(casd_pkg::FILE_VERSION, 1'b0);
        queue_byte(cfg_width, 1'b0);
        queue_byte(cfg_height, 1'b0);
    endfunction

    // Queues one instruction block made of random instructions. The body is cut
    // at the announced length, so the last instruction is often left partial.
    // Now and then the block is cut short, and the caller then starts a new file
    // in the middle of it.
    function automatic int queue_block(output bit cut);
        logic [7:0] body [$];
        int unsigned words;
        int unsigned sel;
        int unsigned n;
        int unsigned keep;
        words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        while (body.size() < 2 * words)
        begin
            sel = $urandom_range(0, 11);
            if (sel <= 3)
            begin
                n = $urandom_range(0, 3);
                body.push_back(8'(n));
                repeat (2 * n) body.push_back(8'($urandom));
            end
            else if (sel <= 7)
            begin
                n = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 6);
                body.push_back(8'h80 | 8'(n));
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
            end
            else if (sel <= 9)
            begin
                body.push_back(casd_pkg::OP_WINDOW);
                repeat (4) body.push_back(8'($urandom));
            end
            else if (sel == 10)
            begin
                body.push_back(8'($urandom_range(8'hC1, 8'hFF)));
            end
            else
            begin
                // A literal of any length; what follows is taken as pixel data.
                body.push_back(8'($urandom_range(0, 127)));
            end
        end
        keep = 2 * words;
        cut = ($urandom_range(0, 14) == 0);
        if (cut) keep = $urandom_range(0, keep - 1);
        queue_byte(8'(words), 1'b0);
        for (n = 0; n < keep; n++) queue_byte(body[n], 1'b0);
        return keep + 1;
    endfunction

    // Queues one file: a header, faulty about half the time, then directives if the header is good.
    // Returns the number of requests that the decoder acts upon.
    function automatic int queue_random_file(input int budget);
        logic [7:0] hdr [7];
        int unsigned fault;
        int unsigned pick;
        int used;
        int k;
        bit cut;
        hdr = '{casd_pkg::MAGIC[0], casd_pkg::MAGIC[1], casd_pkg::MAGIC[2],
                casd_pkg::MAGIC[3], casd_pkg::FILE_VERSION, cfg_width, cfg_height};
        fault = $urandom_range(0, 9);
        case (fault)
            0: hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            1: hdr[4] ^= 8'($urandom_range(1, 255));
            2: hdr[5] ^= 8'($urandom_range(1, 255));
            3: hdr[6] ^= 8'($urandom_range(1, 255));
            4:
            begin
                hdr[$urandom_range(0, 6)] ^= 8'($urandom_range(1, 255));
                hdr[$urandom_range(0, 6)] ^= 8'($urandom_range(1, 255));
            end
            default:
            begin
            end
        endcase
        for (k = 0; k < 7; k++) queue_byte(hdr[k], k == 0);
        used = 7;
        if (fault <= 4)
        begin
            // The decoder ignores these until the next file starts.
            repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
            return used;
        end
        while (used < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                return used;
            end
            else if (pick <= 3)
            begin
                queue_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
                used++;
            end
            else if (pick == 4)
            begin
                queue_byte(8'h00, 1'b0);
                used++;
            end
            else
            begin
                used += queue_block(cut);
                if (cut) return used;
            end
        end
        return used;
    endfunction

    task automatic queue_random_files(input int budget);
        int used;
        used = 0;
        while (used < budget) used += queue_random_file(budget - used);
    endtask

    // Waits until every request is taken and every result has come, then lets
    // the pipeline run empty.
    task automatic settle();
        while (bytes_accepted != bytes_queued || awaited_frames.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [casd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        if (idx == casd_pkg::CFG_EXPECTED_WIDTH) cfg_width = val;
        else cfg_height = val;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_frame_size(input logic [7:0] w, input logic [7:0] h);
        write_reg(casd_pkg::CFG_EXPECTED_WIDTH, w);
        write_reg(casd_pkg::CFG_EXPECTED_HEIGHT, h);
    endtask

    // The run has five phases; the last reuses the reset frame size. Between phases
    // the sender waits until every expected result has come and the block is idle.
    initial
    begin
        logic [7:0] opening [$];
        opening = '{
            8'h80,                          // pause of zero milliseconds
            8'hFF,                          // longest pause
            8'h00,                          // empty instruction block
            8'h07,                          // block of fourteen bytes
            8'h00,                          // literal of no bytes
            8'h01, 8'hFF, 8'h00,            // two literal bytes
            8'hBF, 8'h12, 8'h34,            // pixel repeated 63 times
            8'hC1,                          // unknown opcode
            8'hC0, 8'h0A, 8'h14, 8'h1E, 8'h28, // window change
            8'h05,                          // literal cut off by the block end
            8'h01, 8'h81, 8'hAB,            // repeat cut off by the block end
            8'h85                           // pause of fifty milliseconds
        };
        clk = 1'b0;
        rst_n = 1'b0;
        bs_if.valid = 1'b0;
        bs_if.data_byte = '0;
        bs_if.file_start = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = casd_pkg::CFG_EXPECTED_WIDTH;
        cfg_if.wdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed file with the frame size left at its reset value.
        queue_good_header();
        foreach (opening[i]) queue_byte(opening[i], 1'b0);
        settle();

        // Zero width, so the full-screen window wraps to the top column.
        set_frame_size(8'd0, 8'd255);
        queue_random_files(70);
        settle();

        // Full speed on both sides.
        set_frame_size(8'd255, 8'd0);
        gaps_enabled = 1'b0;
        queue_random_files(70);
        settle();
        gaps_enabled = 1'b1;

        // The receiver holds off while requests keep coming, so the block fills
        // up and has to stall its input.
        set_frame_size(8'($urandom), 8'($urandom));
        hold_requests++;
        queue_good_header();
        queue_random_files(120);
        settle();

        // Back to the reset frame size.
        set_frame_size(casd_pkg::WIDTH_RESET, casd_pkg::HEIGHT_RESET);
        queue_random_files(100);
        settle();

        if (awaited_frames.size() != 0)
            note_failure($sformatf("%0d results never arrived", awaited_frames.size()));
        $display("Decoded %0d file bytes over five frame-size phases in %0d cycles.",
                 bytes_accepted, cycle_count);
        $display("Checked %0d display writes, %0d pauses and %0d header errors; %0d failures.",
                 writes_seen, pauses_seen, errors_seen, failures);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/casd_pkg.sv
rtl/casd_in_if.sv
rtl/casd_out_if.sv
rtl/casd_cfg_if.sv
rtl/casd_parser.sv
rtl/color_animation_stream_decoder.sv
rtl/casd_checker.sv
verif/tb_top.sv
